[sv/atapt_pkg.sv]
// Shared types, constants and codes for the ATA PIO request to task-file block.
package atapt_pkg;

	localparam int DEVICE_SLOTS        = 1;
	localparam int MAX_REQUEST_SECTORS = 16384;
	localparam int CHUNK_SECTORS       = 256;
	localparam int MAX_CMDS            = 64;

	localparam int LBA_W      = 28;
	localparam int CNT_W      = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;
	localparam int SURF_W     = 24;
	localparam int CHUNK_W    = $clog2(CHUNK_SECTORS + 1);
	localparam int DIV_CNT_W  = $clog2(LBA_W);

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_PARAM     = 2'd2;

	localparam logic [7:0] ATA_READ  = 8'h20;
	localparam logic [7:0] ATA_WRITE = 8'h30;
	localparam logic [7:0] DH_LBA    = 8'hE0;
	localparam logic [7:0] DH_CHS    = 8'hA0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ADDR_MODE     = 3'd0,
		CFG_DRIVE_READY   = 3'd1,
		CFG_TOTAL_SECTORS = 3'd2,
		CFG_SPT           = 3'd3,
		CFG_CYLINDERS     = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ADDR,
		S_DIV1,
		S_DIV2,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic             addr_mode;
		logic             drive_ready;
		logic [LBA_W-1:0] total_sectors;
		logic [7:0]       sectors_per_track;
		logic [15:0]      cylinders;
	} cfg_t;

	typedef struct packed {
		logic load_req;
		logic load_status;
		logic init_chunk;
		logic div_start;
		logic div_sel;    // 0: lba / surface, 1: remainder / sectors per track
		logic cap_head;
		logic cap_cyl;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic req_bad;
		logic lba_mode;
		logic div_done;
		logic last_chunk;
		logic out_free;
	} dp_stat_t;

endpackage

[sv/atapt_ifs.sv]
// Request and result channel interfaces.
interface atapt_req_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic                        device;
	logic [atapt_pkg::LBA_W-1:0] start_sector;
	logic [atapt_pkg::CNT_W-1:0] sector_count;

	modport source (output valid, cmd, device, start_sector, sector_count, input ready);
	modport sink   (input valid, cmd, device, start_sector, sector_count, output ready);
endinterface

interface atapt_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       command_valid;
	logic [7:0] device_head;
	logic [7:0] sector_number;
	logic [7:0] cylinder_low;
	logic [7:0] cylinder_high;
	logic [7:0] count_byte;
	logic [7:0] command_byte;
	logic       last;

	modport source (output valid, status, command_valid, device_head, sector_number,
		cylinder_low, cylinder_high, count_byte, command_byte, last, input ready);
	modport sink   (input valid, status, command_valid, device_head, sector_number,
		cylinder_low, cylinder_high, count_byte, command_byte, last, output ready);
endinterface

[sv/atapt_div.sv]
// Restoring divider, one quotient bit per cycle, for the CHS address split.
module atapt_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [atapt_pkg::LBA_W-1:0]  dividend,
	input  logic [atapt_pkg::SURF_W-1:0] divisor,
	output logic                         done,
	output logic [atapt_pkg::LBA_W-1:0]  quotient,
	output logic [atapt_pkg::SURF_W-1:0] remainder
);

	logic                             busy_q;
	logic                             done_q;
	logic [atapt_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [atapt_pkg::SURF_W-1:0]     acc_q;
	logic [atapt_pkg::SURF_W-1:0]     dvs_q;
	logic [atapt_pkg::LBA_W-1:0]      quo_q;
	logic [atapt_pkg::SURF_W:0]       trial;
	logic                             fits;

	assign trial = {acc_q, quo_q[atapt_pkg::LBA_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == atapt_pkg::DIV_CNT_W'(atapt_pkg::LBA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract when it fits
			if (fits) begin
				acc_q <= atapt_pkg::SURF_W'(trial - {1'b0, dvs_q});
			end else begin
				acc_q <= trial[atapt_pkg::SURF_W-1:0];
			end
			quo_q <= {quo_q[atapt_pkg::LBA_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = acc_q;

endmodule

[sv/atapt_ctrl.sv]
// Controller state machine: request check, chunk sequencing and divider steps.
module atapt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  atapt_pkg::dp_stat_t  stat,
	output atapt_pkg::dp_cmd_t   cmd
);

	atapt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= atapt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			atapt_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = atapt_pkg::S_CHECK;
				end
			end
			atapt_pkg::S_CHECK: begin
				if (stat.req_bad) begin
					// single status item, hold until the output register is free
					if (stat.out_free) begin
						cmd.load_status = 1'b1;
						state_d         = atapt_pkg::S_IDLE;
					end
				end else begin
					cmd.init_chunk = 1'b1;
					state_d        = atapt_pkg::S_ADDR;
				end
			end
			atapt_pkg::S_ADDR: begin
				if (stat.lba_mode) begin
					state_d = atapt_pkg::S_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = 1'b0;
					state_d       = atapt_pkg::S_DIV1;
				end
			end
			atapt_pkg::S_DIV1: begin
				if (stat.div_done) begin
					cmd.cap_head  = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = 1'b1;
					state_d       = atapt_pkg::S_DIV2;
				end
			end
			atapt_pkg::S_DIV2: begin
				if (stat.div_done) begin
					cmd.cap_cyl = 1'b1;
					state_d     = atapt_pkg::S_EMIT;
				end
			end
			atapt_pkg::S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = stat.last_chunk ? atapt_pkg::S_IDLE : atapt_pkg::S_ADDR;
				end
			end
			default: begin
				state_d = atapt_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[sv/atapt_dp.sv]
// Datapath: request registers, checks, chunk counters, address forming, output register.
module atapt_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  atapt_pkg::cfg_t     cfg,
	input  atapt_pkg::dp_cmd_t  cmd,
	output atapt_pkg::dp_stat_t stat,
	atapt_req_if.sink           req,
	atapt_res_if.source         res
);

	logic                          wr_q;
	logic                          dev_q;
	logic [atapt_pkg::LBA_W-1:0]   start_q;
	logic [atapt_pkg::CNT_W-1:0]   count_q;
	logic [atapt_pkg::LBA_W-1:0]   next_sector_q;
	logic [atapt_pkg::CNT_W-1:0]   remaining_q;
	logic [atapt_pkg::SURF_W-1:0]  surface_q;
	logic [7:0]                    head_q;
	logic [15:0]                   cyl_q;
	logic [7:0]                    sn_q;

	logic                          out_valid_q;
	logic [1:0]                    status_q;
	logic                          cmd_valid_q;
	logic [7:0]                    dh_q;
	logic [7:0]                    snum_q;
	logic [7:0]                    cl_q;
	logic [7:0]                    ch_q;
	logic [7:0]                    cnt_byte_q;
	logic [7:0]                    cmd_byte_q;
	logic                          last_q;

	logic [7:0]                    spt_eff;
	logic [15:0]                   cyl_eff;
	logic                          not_found;
	logic                          range_bad;
	logic                          size_bad;
	logic                          zero_cnt;
	logic [1:0]                    err_code;
	logic [atapt_pkg::CHUNK_W-1:0] chunk_n;
	logic                          div_done;
	logic [atapt_pkg::LBA_W-1:0]   div_quo;
	logic [atapt_pkg::SURF_W-1:0]  div_rem;
	logic [atapt_pkg::LBA_W-1:0]   div_dividend;
	logic [atapt_pkg::SURF_W-1:0]  div_divisor;
	logic [7:0]                    dh_f, sn_f, cl_f, ch_f;

	assign spt_eff = (cfg.sectors_per_track == 8'd0) ? 8'd1 : cfg.sectors_per_track;
	assign cyl_eff = (cfg.cylinders == 16'd0) ? 16'd1 : cfg.cylinders;

	// request checks
	assign not_found = ({1'b0, dev_q} >= 2'(atapt_pkg::DEVICE_SLOTS)) || !cfg.drive_ready;
	assign range_bad = ({1'b0, start_q} + (atapt_pkg::LBA_W + 1)'(count_q))
		> {1'b0, cfg.total_sectors};
	assign size_bad  = (count_q > atapt_pkg::CNT_W'(atapt_pkg::MAX_REQUEST_SECTORS))
		|| ({1'b0, count_q} > (atapt_pkg::CNT_W + 1)'(atapt_pkg::MAX_CMDS
		* atapt_pkg::CHUNK_SECTORS));
	assign zero_cnt  = count_q == '0;
	assign err_code  = not_found ? atapt_pkg::ST_NOT_FOUND
		: ((range_bad || size_bad) ? atapt_pkg::ST_PARAM : atapt_pkg::ST_OK);

	assign chunk_n = (remaining_q > atapt_pkg::CNT_W'(atapt_pkg::CHUNK_SECTORS))
		? atapt_pkg::CHUNK_W'(atapt_pkg::CHUNK_SECTORS)
		: remaining_q[atapt_pkg::CHUNK_W-1:0];

	assign div_dividend = cmd.div_sel ? atapt_pkg::LBA_W'(div_rem) : next_sector_q;
	assign div_divisor  = cmd.div_sel ? atapt_pkg::SURF_W'(spt_eff) : surface_q;

	atapt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// task-file bytes for the current chunk
	always_comb begin
		if (cfg.addr_mode) begin
			dh_f = atapt_pkg::DH_LBA | {3'b000, dev_q, next_sector_q[27:24]};
			sn_f = next_sector_q[7:0];
			cl_f = next_sector_q[15:8];
			ch_f = next_sector_q[23:16];
		end else begin
			// high head bits merge into the fixed bits
			dh_f = head_q | {3'b000, dev_q, 4'b0000} | atapt_pkg::DH_CHS;
			sn_f = sn_q;
			cl_f = cyl_q[7:0];
			ch_f = cyl_q[15:8];
		end
	end

	always_ff @(posedge clk) begin
		surface_q <= atapt_pkg::SURF_W'(spt_eff) * atapt_pkg::SURF_W'(cyl_eff);
		if (cmd.load_req) begin
			wr_q    <= req.cmd;
			dev_q   <= req.device;
			start_q <= req.start_sector;
			count_q <= req.sector_count;
		end
		if (cmd.cap_head) begin
			head_q <= div_quo[7:0];
		end
		if (cmd.cap_cyl) begin
			cyl_q <= div_quo[15:0];
			sn_q  <= div_rem[7:0] + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_sector_q <= '0;
			remaining_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.init_chunk) begin
				next_sector_q <= start_q;
				remaining_q   <= count_q;
			end else if (cmd.emit) begin
				next_sector_q <= next_sector_q + atapt_pkg::LBA_W'(chunk_n);
				remaining_q   <= remaining_q - atapt_pkg::CNT_W'(chunk_n);
			end
			if (cmd.load_status || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_status) begin
			status_q   <= err_code;
			cmd_valid_q <= 1'b0;
			dh_q       <= '0;
			snum_q     <= '0;
			cl_q       <= '0;
			ch_q       <= '0;
			cnt_byte_q <= '0;
			cmd_byte_q <= '0;
			last_q     <= 1'b1;
		end else if (cmd.emit) begin
			status_q    <= atapt_pkg::ST_OK;
			cmd_valid_q <= 1'b1;
			dh_q        <= dh_f;
			snum_q      <= sn_f;
			cl_q        <= cl_f;
			ch_q        <= ch_f;
			cnt_byte_q  <= chunk_n[7:0];
			cmd_byte_q  <= wr_q ? atapt_pkg::ATA_WRITE : atapt_pkg::ATA_READ;
			last_q      <= remaining_q == atapt_pkg::CNT_W'(chunk_n);
		end
	end

	assign stat.req_bad    = not_found || range_bad || size_bad || zero_cnt;
	assign stat.lba_mode   = cfg.addr_mode;
	assign stat.div_done   = div_done;
	assign stat.last_chunk = remaining_q == atapt_pkg::CNT_W'(chunk_n);
	assign stat.out_free   = !out_valid_q || res.ready;

	assign res.valid         = out_valid_q;
	assign res.status        = status_q;
	assign res.command_valid = cmd_valid_q;
	assign res.device_head   = dh_q;
	assign res.sector_number = snum_q;
	assign res.cylinder_low  = cl_q;
	assign res.cylinder_high = ch_q;
	assign res.count_byte    = cnt_byte_q;
	assign res.command_byte  = cmd_byte_q;
	assign res.last          = last_q;

endmodule

[sv/ata_pio_request_to_taskfile_top.sv]
// Top level: configuration registers, controller, datapath and checks.
// One request is taken at a time; the next is accepted once the last result of the
// current one sits in the output register. A request that fails its checks or has a
// zero count gives one status item, loaded from the check state once the output
// register is free. A valid request gives one task-file item per chunk of up to 256
// sectors: in LBA mode each chunk goes from the address state straight to emit; in CHS
// mode it first runs the shared one-bit-per-cycle divider twice (28 steps for lba /
// surface, 28 for the remainder / sectors per track).
module ata_pio_request_to_taskfile_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [atapt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [atapt_pkg::CFG_DATA_W-1:0]  cfg_data,
	atapt_req_if.sink                         req,
	atapt_res_if.source                       res
);

	atapt_pkg::cfg_t     cfg_q;
	atapt_pkg::dp_cmd_t  cmd;
	atapt_pkg::dp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.addr_mode         <= 1'b1;
			cfg_q.drive_ready       <= 1'b0;
			cfg_q.total_sectors     <= '0;
			cfg_q.sectors_per_track <= 8'd1;
			cfg_q.cylinders         <= 16'd1;
		end else if (cfg_we) begin
			unique case (atapt_pkg::cfg_idx_t'(cfg_index))
				atapt_pkg::CFG_ADDR_MODE:     cfg_q.addr_mode         <= cfg_data[0];
				atapt_pkg::CFG_DRIVE_READY:   cfg_q.drive_ready       <= cfg_data[0];
				atapt_pkg::CFG_TOTAL_SECTORS: cfg_q.total_sectors     <= cfg_data;
				atapt_pkg::CFG_SPT:           cfg_q.sectors_per_track <= cfg_data[7:0];
				atapt_pkg::CFG_CYLINDERS:     cfg_q.cylinders         <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	atapt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	atapt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.stat   (stat),
		.req    (req),
		.res    (res)
	);

	// one request at a time: no new item right after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while previous one in flight");

	// status-only items always close their request
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.command_valid |-> res.last)
		else $error("item without command not marked last");

	// error items never carry a command
	a_err_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != atapt_pkg::ST_OK |-> !res.command_valid)
		else $error("error item carries a command");

	// a command item never has a zero-filled command code
	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.command_valid |->
		(res.command_byte == atapt_pkg::ATA_READ || res.command_byte == atapt_pkg::ATA_WRITE))
		else $error("command item with bad command code");

endmodule

[tb/sv/ata_pio_request_to_taskfile_top_test.sv]
// Self-checking testbench for the ATA PIO request to task-file block.
module ata_pio_request_to_taskfile_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam bit [27:0] LAST_LBA = 28'hFFFFFFF;

	typedef struct packed {
		logic [1:0] status;
		logic       command_valid;
		logic [7:0] device_head;
		logic [7:0] sector_number;
		logic [7:0] cylinder_low;
		logic [7:0] cylinder_high;
		logic [7:0] count_byte;
		logic [7:0] command_byte;
		logic       last;
	} taskfile_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [atapt_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [atapt_pkg::CFG_DATA_W-1:0] cfg_data;

	atapt_req_if req_ch ();
	atapt_res_if res_ch ();

	ata_pio_request_to_taskfile_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	// Shadow of the drive configuration
	bit        lba_mode      = 1'b1;
	bit        drive_ok      = 1'b0;
	bit [27:0] disk_sectors  = '0;
	bit [7:0]  track_sectors = 8'd1;
	bit [15:0] cyl_count     = 16'd1;

	taskfile_t taskfile_q[$];
	int mismatches     = 0;
	int requests_sent  = 0;
	int results_seen   = 0;
	int commands_seen  = 0;
	int idle_cycles    = 0;
	int send_idle_pct  = 0;
	int res_stall_pct  = 0;
	int hold_cycles    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void push_status(logic [1:0] st);
		taskfile_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		taskfile_q.push_back(r);
	endfunction

	function automatic void predict_request(bit wr, bit dev, bit [27:0] start, bit [14:0] count);
		taskfile_t r;
		bit [27:0] lba;
		int unsigned left, n, spt, cyl, surf, head, cyl_no, cmds;
		cmds = (count + atapt_pkg::CHUNK_SECTORS - 1) / atapt_pkg::CHUNK_SECTORS;
		if (int'(dev) >= atapt_pkg::DEVICE_SLOTS || !drive_ok)
			push_status(atapt_pkg::ST_NOT_FOUND);
		else if (64'(start) + 64'(count) > 64'(disk_sectors))
			push_status(atapt_pkg::ST_PARAM);
		else if (count > atapt_pkg::MAX_REQUEST_SECTORS || cmds > atapt_pkg::MAX_CMDS)
			push_status(atapt_pkg::ST_PARAM);
		else if (count == 0)
			push_status(atapt_pkg::ST_OK);
		else begin
			lba = start;
			left = count;
			spt = (track_sectors == 0) ? 1 : 32'(track_sectors);
			cyl = (cyl_count == 0) ? 1 : 32'(cyl_count);
			surf = spt * cyl;
			while (left > 0) begin
				n = (left < atapt_pkg::CHUNK_SECTORS) ? left : atapt_pkg::CHUNK_SECTORS;
				r = '0;
				r.status = atapt_pkg::ST_OK;
				r.command_valid = 1'b1;
				if (lba_mode) begin
					r.device_head = atapt_pkg::DH_LBA | {3'b000, dev, lba[27:24]};
					r.sector_number = lba[7:0];
					r.cylinder_low = lba[15:8];
					r.cylinder_high = lba[23:16];
				end else begin
					// head bits above 3 fold into the fixed bits
					head = lba / surf;
					cyl_no = (lba % surf) / spt;
					r.sector_number = 8'((lba % spt) + 1);
					r.device_head = 8'(head) | {3'b000, dev, 4'b0000} | atapt_pkg::DH_CHS;
					r.cylinder_low = cyl_no[7:0];
					r.cylinder_high = cyl_no[15:8];
				end
				r.count_byte = n[7:0];
				r.command_byte = wr ? atapt_pkg::ATA_WRITE : atapt_pkg::ATA_READ;
				left -= n;
				lba = lba + 28'(n);
				r.last = (left == 0);
				taskfile_q.push_back(r);
			end
		end
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		taskfile_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (taskfile_q.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing pending, expected none, got status %0d",
					$time, res_ch.status);
			end else begin
				want = taskfile_q.pop_front();
				check_field("status", 8'(want.status), 8'(res_ch.status));
				check_field("command_valid", 8'(want.command_valid),
					8'(res_ch.command_valid));
				check_field("device_head", want.device_head, res_ch.device_head);
				check_field("sector_number", want.sector_number, res_ch.sector_number);
				check_field("cylinder_low", want.cylinder_low, res_ch.cylinder_low);
				check_field("cylinder_high", want.cylinder_high, res_ch.cylinder_high);
				check_field("count_byte", want.count_byte, res_ch.count_byte);
				check_field("command_byte", want.command_byte, res_ch.command_byte);
				check_field("last", 8'(want.last), 8'(res_ch.last));
				results_seen++;
				if (want.command_valid)
					commands_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// Result side: random stalls, or a counted hold-off when one is requested
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= res_stall_pct);
			end
		end
	end

	task automatic write_reg(atapt_pkg::cfg_idx_t idx, logic [atapt_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_config(bit mode, bit ready, bit [27:0] total, bit [7:0] spt,
			bit [15:0] cyl);
		write_reg(atapt_pkg::CFG_ADDR_MODE, atapt_pkg::CFG_DATA_W'(mode));
		write_reg(atapt_pkg::CFG_DRIVE_READY, atapt_pkg::CFG_DATA_W'(ready));
		write_reg(atapt_pkg::CFG_TOTAL_SECTORS, atapt_pkg::CFG_DATA_W'(total));
		write_reg(atapt_pkg::CFG_SPT, atapt_pkg::CFG_DATA_W'(spt));
		write_reg(atapt_pkg::CFG_CYLINDERS, atapt_pkg::CFG_DATA_W'(cyl));
		cfg_we <= 1'b0;
		lba_mode = mode;
		drive_ok = ready;
		disk_sectors = total;
		track_sectors = spt;
		cyl_count = cyl;
		@(posedge clk);
	endtask

	// Drop valid and wait until every pending result is back
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (taskfile_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_request(bit wr, bit dev, bit [27:0] start, bit [14:0] count);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= wr;
		req_ch.device <= dev;
		req_ch.start_sector <= start;
		req_ch.sector_count <= count;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_request(wr, dev, start, count);
		requests_sent++;
	endtask

	task automatic random_request();
		bit wr, dev;
		bit [27:0] start;
		bit [14:0] count;
		int pick;
		wr = 1'($urandom_range(0, 1));
		dev = 1'b0;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			dev = 1'b1;
			start = 28'($urandom);
			count = 15'($urandom_range(0, 32767));
		end else if (pick < 14) begin
			start = 28'($urandom);
			count = 15'($urandom);
		end else if (pick < 18) begin
			start = '0;
			count = 15'($urandom_range(atapt_pkg::MAX_REQUEST_SECTORS + 1, 32767));
		end else begin
			if (pick < 24)
				count = '0;
			else if (pick < 90)
				count = 15'($urandom_range(1, 600));
			else
				count = 15'($urandom_range(601, atapt_pkg::MAX_REQUEST_SECTORS));
			if (count > disk_sectors)
				start = 28'($urandom);
			else if ($urandom_range(0, 9) == 0)
				start = disk_sectors - count;
			else
				start = 28'($urandom_range(0, disk_sectors - count));
		end
		send_request(wr, dev, start, count);
	endtask

	task automatic random_config(bit mode);
		bit [27:0] total;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			total = LAST_LBA;
		else if (pick < 8)
			total = 28'($urandom);
		else
			total = 28'($urandom_range(0, 2000));
		load_config(mode, $urandom_range(0, 9) != 0, total, 8'($urandom_range(0, 255)),
			16'($urandom_range(0, 65535)));
	endtask

	// Reset values: drive not ready, so every request reports not found
	task automatic test_reset_state();
		send_request(1'b0, 1'b0, 28'd0, 15'd1);
		send_request(1'b1, 1'b1, LAST_LBA, 15'd0);
		send_request(1'b0, 1'b0, 28'd0, 15'd0);
		settle();
	endtask

	task automatic test_lba_limits();
		load_config(1'b1, 1'b1, LAST_LBA, 8'd1, 16'd1);
		send_request(1'b0, 1'b0, 28'd0, 15'd0);
		send_request(1'b0, 1'b0, 28'd0, 15'd1);
		send_request(1'b1, 1'b0, 28'hFFFFFFE, 15'd1);
		send_request(1'b0, 1'b1, 28'd0, 15'd1);
		send_request(1'b1, 1'b0, LAST_LBA, 15'd1);
		send_request(1'b0, 1'b0, LAST_LBA, 15'd0);
		send_request(1'b1, 1'b0, 28'h0ABCDEF, 15'd256);
		send_request(1'b0, 1'b0, 28'h0000100, 15'd257);
		send_request(1'b1, 1'b0, 28'hFFFBFFF, 15'd16384);
		send_request(1'b0, 1'b0, 28'd0, 15'd16385);
		send_request(1'b1, 1'b0, 28'd0, 15'h7FFF);
		settle();
	endtask

	task automatic test_sector_bound();
		load_config(1'b1, 1'b1, 28'd1000, 8'd1, 16'd1);
		send_request(1'b0, 1'b0, 28'd1000, 15'd0);
		send_request(1'b0, 1'b0, 28'd1001, 15'd0);
		send_request(1'b1, 1'b0, 28'd999, 15'd1);
		send_request(1'b0, 1'b0, 28'd999, 15'd2);
		settle();
		load_config(1'b1, 1'b1, 28'd0, 8'd1, 16'd1);
		send_request(1'b0, 1'b0, 28'd0, 15'd0);
		send_request(1'b1, 1'b0, 28'd0, 15'd1);
		settle();
	endtask

	task automatic test_chs_mapping();
		load_config(1'b0, 1'b1, LAST_LBA, 8'd255, 16'd65535);
		send_request(1'b0, 1'b0, 28'd0, 15'd1);
		send_request(1'b1, 1'b0, 28'd16711420, 15'd300);
		send_request(1'b0, 1'b0, 28'hFFFFFFE, 15'd1);
		settle();
		// zero divisors act as one, so the head number overflows
		load_config(1'b0, 1'b1, LAST_LBA, 8'd0, 16'd0);
		send_request(1'b1, 1'b0, 28'h1234567, 15'd2);
		settle();
		load_config(1'b0, 1'b1, LAST_LBA, 8'd255, 16'd1);
		send_request(1'b0, 1'b0, 28'd5000, 15'd600);
		settle();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  res_stall_pct = 0;  end
				1: begin send_idle_pct = 79; res_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  res_stall_pct = 79; end
				default: begin send_idle_pct = 26; res_stall_pct = 26; end
			endcase
			for (int half = 0; half < 2; half++) begin
				random_config(half == 0);
				repeat (9) random_request();
				settle();
			end
		end
		send_idle_pct = 0;
		res_stall_pct = 0;
	endtask

	// Hold the result side off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		load_config(1'b1, 1'b1, LAST_LBA, 8'd1, 16'd1);
		hold_cycles = 400;
		repeat (6)
			send_request(1'($urandom_range(0, 1)), 1'b0,
				28'($urandom_range(0, 28'h0FF0000)), 15'($urandom_range(257, 1024)));
		settle();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= 1'b0;
		req_ch.device <= 1'b0;
		req_ch.start_sector <= '0;
		req_ch.sector_count <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_lba_limits();
		test_sector_bound();
		test_chs_mapping();
		test_random_traffic();
		test_backpressure();
		settle();
		$display("Sent %0d requests; checked %0d results, %0d of them task-file commands.",
			requests_sent, results_seen, commands_seen);
		$display("Covered LBA28 and CHS mapping, error checks, zero counts, idle and stall mixes.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
sv/atapt_pkg.sv
sv/atapt_ifs.sv
sv/atapt_div.sv
sv/atapt_ctrl.sv
sv/atapt_dp.sv
sv/ata_pio_request_to_taskfile_top.sv
tb/sv/ata_pio_request_to_taskfile_top_test.sv
